// ===== rtl/rmsprop_weight_update_defines.svh =====
// Assertion macros shared by the RMSprop weight update RTL.
`ifndef RMSPROP_WEIGHT_UPDATE_DEFINES_SVH
`define RMSPROP_WEIGHT_UPDATE_DEFINES_SVH

`ifndef SYNTH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RWU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmsprop_weight_update: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmsprop_weight_update: next-cycle check failed");

`else

`define RWU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rwu_pkg.sv =====
// Types and constants of the RMSprop weight update block.
`timescale 1ns / 1ps

package rwu_pkg;

    localparam int DATA_W  = 32;
    localparam int RATE_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int ROOT_W  = 24;
    localparam int SQ_REM_W = 25;
    localparam int DIV_W   = 48;
    localparam int DV_REM_W = 25;

    localparam logic [RATE_W-1:0] LR_RESET = 16'd66;
    localparam logic [RATE_W-1:0] DR_RESET = 16'd58982;

    typedef enum logic [0:0] {
        REG_LEARNING_RATE = 1'b0,
        REG_DECAY_RATE    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              valid;
        logic              inrange;
        logic              neg;
        logic              sat;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] weight;
    } t_item;

endpackage

// ===== rtl/rmsprop_weight_update.sv =====
// RMSprop weight update: cache update, pipelined square root and divider, output queue.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_layer_index, i_element_index, i_gradient,
//                                          i_weight_in
// output    out        o_valid / i_stall   o_weight_out, o_saturated
// config    in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// One item is accepted per cycle while o_stall is low.
// The pipeline depth is set mainly by the 24-step square root and the 48-step divider pipelines.
// After reset a clearing pass writes zero to every cache entry, one per cycle;
// o_stall is high meanwhile.
// An output stall never stops the pipeline: results queue in a 128-entry buffer, and
// outside the clearing pass o_stall rises only when that many items are outstanding.

`include "rmsprop_weight_update_defines.svh"

module rmsprop_weight_update #(
    parameter int LAYER_COUNT        = 8,
    parameter int ELEMENTS_PER_LAYER = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_layer_index,
    input  logic [9:0]          i_element_index,
    input  logic signed [31:0]  i_gradient,
    input  logic signed [31:0]  i_weight_in,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_weight_out,
    output logic                o_saturated,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DATA_W      = rwu_pkg::DATA_W;
    localparam int RATE_W      = rwu_pkg::RATE_W;
    localparam int ROOT_W      = rwu_pkg::ROOT_W;
    localparam int SQ_REM_W    = rwu_pkg::SQ_REM_W;
    localparam int DIV_W       = rwu_pkg::DIV_W;
    localparam int DV_REM_W    = rwu_pkg::DV_REM_W;
    localparam int CACHE_DEPTH = LAYER_COUNT * ELEMENTS_PER_LAYER;
    localparam int ADDR_W      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int HIST_N      = 4;
    localparam int FIFO_DEPTH  = 128;
    localparam int FW          = $clog2(FIFO_DEPTH);
    localparam logic [FW:0] FIFO_FULL = (FW+1)'(FIFO_DEPTH);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CACHE_DEPTH - 1);

    // Configuration registers.
    logic [RATE_W-1:0] r_learning_rate;
    logic [RATE_W-1:0] r_decay_rate;
    logic              n_cfg_we;

    assign pready   = 1'b1;
    assign n_cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= rwu_pkg::LR_RESET;
            r_decay_rate    <= rwu_pkg::DR_RESET;
        end else if (n_cfg_we) begin
            if (paddr[2] == rwu_pkg::REG_DECAY_RATE) begin
                r_decay_rate <= pwdata[RATE_W-1:0];
            end else begin
                r_learning_rate <= pwdata[RATE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rwu_pkg::REG_DECAY_RATE) begin
            prdata = {16'd0, r_decay_rate};
        end else begin
            prdata = {16'd0, r_learning_rate};
        end
    end

    // Clearing pass and credit accounting.
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [FW:0]       r_used;
    logic              n_acc;
    logic              n_take;

    assign o_stall = r_clr_busy | (r_used == FIFO_FULL);
    assign n_acc   = i_valid & ~o_stall;
    assign n_take  = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_used     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_used <= r_used + (FW+1)'(n_acc) - (FW+1)'(n_take);
        end
    end

    // Input decode.
    rwu_pkg::t_item    n_in;
    logic [31:0]       n_addr_full;
    logic [ADDR_W-1:0] n_rd_addr;

    always_comb begin
        n_addr_full = 32'(i_layer_index) * 32'(ELEMENTS_PER_LAYER) + 32'(i_element_index);
        n_rd_addr   = n_addr_full[ADDR_W-1:0];
        n_in.valid   = n_acc;
        n_in.inrange = (32'(i_layer_index) < 32'(LAYER_COUNT))
                     && (32'(i_element_index) < 32'(ELEMENTS_PER_LAYER));
        n_in.neg     = i_gradient[31];
        n_in.sat     = 1'b0;
        n_in.mag     = i_gradient[31] ? (~i_gradient + 32'd1) : i_gradient;
        n_in.weight  = i_weight_in;
    end

    // Cache memory.
    logic [DATA_W-1:0] r_cache_mem [CACHE_DEPTH];
    logic [DATA_W-1:0] r_mem_rd;
    logic              n_mem_we;
    logic [ADDR_W-1:0] n_mem_waddr;
    logic [DATA_W-1:0] n_mem_wdata;
    logic              n_upd_we;
    logic [DATA_W-1:0] n_new;
    logic [ADDR_W-1:0] r4_addr;

    always_comb begin
        if (r_clr_busy) begin
            n_mem_we    = 1'b1;
            n_mem_waddr = r_clr_addr;
            n_mem_wdata = '0;
        end else begin
            n_mem_we    = n_upd_we;
            n_mem_waddr = r4_addr;
            n_mem_wdata = n_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            r_cache_mem[n_mem_waddr] <= n_mem_wdata;
        end
        r_mem_rd <= r_cache_mem[n_rd_addr];
    end

    // Stages 1 to 4: square of the gradient and the (1 - rho) term.
    rwu_pkg::t_item    r1_item, r2_item, r3_item, r4_item;
    logic [ADDR_W-1:0] r1_addr, r2_addr, r3_addr;
    logic [DATA_W-1:0] r2_mem, r3_mem, r4_mem;
    logic [63:0]       r2_sq;
    logic [16:0]       n_one_minus;
    logic [48:0]       r3_plo;
    logic [32:0]       r3_phi;
    logic [64:0]       n_term_full;
    logic [48:0]       r4_term;

    assign n_one_minus = 17'h10000 - {1'b0, r_decay_rate};
    assign n_term_full = {r3_phi, 32'd0} + 65'(r3_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_item <= '0;
            r2_item <= '0;
            r3_item <= '0;
            r4_item <= '0;
        end else begin
            r1_item <= n_in;
            r2_item <= r1_item;
            r3_item <= r2_item;
            r4_item <= r3_item;
        end
        r1_addr <= n_rd_addr;
        r2_addr <= r1_addr;
        r2_mem  <= r_mem_rd;
        r2_sq   <= 64'(r1_item.mag) * 64'(r1_item.mag);
        r3_addr <= r2_addr;
        r3_mem  <= r2_mem;
        r3_plo  <= 49'(r2_sq[47:16]) * 49'(n_one_minus);
        r3_phi  <= 33'(r2_sq[63:48]) * 33'(n_one_minus);
        r4_addr <= r3_addr;
        r4_mem  <= r3_mem;
        r4_term <= n_term_full[64:16];
    end

    // Stage 5: cache update with forwarding from recent writes.
    logic [HIST_N-1:0] r_h_valid;
    logic [ADDR_W-1:0] r_h_addr [HIST_N];
    logic [DATA_W-1:0] r_h_data [HIST_N];
    logic [DATA_W-1:0] n_old;
    logic [47:0]       n_prod;
    logic [49:0]       n_sum;
    logic              n_csat;

    always_comb begin
        n_old = r4_mem;
        for (int k = HIST_N - 1; k >= 0; k--) begin
            if (r_h_valid[k] && (r_h_addr[k] == r4_addr)) begin
                n_old = r_h_data[k];
            end
        end
        n_prod   = 48'(n_old) * 48'(r_decay_rate);
        n_sum    = 50'(n_prod[47:16]) + 50'(r4_term);
        n_csat   = n_sum > 50'h0_FFFF_FFFF;
        n_new    = n_csat ? '1 : n_sum[DATA_W-1:0];
        n_upd_we = r4_item.valid & r4_item.inrange;
    end

    always_ff @(posedge i_clk) begin
        r_h_addr[0] <= r4_addr;
        r_h_data[0] <= n_new;
        for (int k = 1; k < HIST_N; k++) begin
            r_h_addr[k] <= r_h_addr[k-1];
            r_h_data[k] <= r_h_data[k-1];
        end
        if (!i_rst_n) begin
            r_h_valid <= '0;
        end else begin
            r_h_valid <= {r_h_valid[HIST_N-2:0], n_upd_we};
        end
    end

    // Square root pipeline, one result bit per stage.
    rwu_pkg::t_item      r_sq_item  [ROOT_W+1];
    logic [DATA_W-1:0]   r_sq_cache [ROOT_W+1];
    logic [SQ_REM_W-1:0] r_sq_rem   [ROOT_W+1];
    logic [ROOT_W-1:0]   r_sq_root  [ROOT_W+1];
    rwu_pkg::t_item      n_upd_item;

    always_comb begin
        n_upd_item     = r4_item;
        n_upd_item.sat = n_csat & r4_item.inrange;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_item[0] <= '0;
        end else begin
            r_sq_item[0] <= n_upd_item;
        end
        r_sq_cache[0] <= n_new;
        r_sq_rem[0]   <= '0;
        r_sq_root[0]  <= '0;
    end

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sq
        logic [47:0]         v;
        logic [26:0]         rem_next;
        logic [26:0]         trial;
        logic                ge;
        logic [26:0]         diff;

        always_comb begin
            v        = {r_sq_cache[i], 16'd0};
            rem_next = {r_sq_rem[i], v[47-2*i -: 2]};
            trial    = 27'({r_sq_root[i], 2'b01});
            ge       = rem_next >= trial;
            diff     = rem_next - trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_item[i+1] <= '0;
            end else begin
                r_sq_item[i+1] <= r_sq_item[i];
            end
            r_sq_cache[i+1] <= r_sq_cache[i];
            r_sq_rem[i+1]   <= ge ? diff[SQ_REM_W-1:0] : rem_next[SQ_REM_W-1:0];
            r_sq_root[i+1]  <= {r_sq_root[i][ROOT_W-2:0], ge};
        end
    end

    // Divider pipeline, one quotient bit per stage.
    rwu_pkg::t_item      r_dv_item [DIV_W+1];
    logic [DV_REM_W-1:0] r_dv_den  [DIV_W+1];
    logic [DIV_W-1:0]    r_dv_num  [DIV_W+1];
    logic [DV_REM_W-1:0] r_dv_rem  [DIV_W+1];
    logic [DIV_W-1:0]    r_dv_q    [DIV_W+1];
    logic [DIV_W-1:0]    n_num;

    always_comb begin
        n_num = DIV_W'(r_sq_item[ROOT_W].mag) * DIV_W'(r_learning_rate);
        if (!r_sq_item[ROOT_W].inrange) begin
            n_num = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_item[0] <= '0;
        end else begin
            r_dv_item[0] <= r_sq_item[ROOT_W];
        end
        r_dv_den[0]  <= DV_REM_W'(r_sq_root[ROOT_W]) + 1'b1;
        r_dv_num[0]  <= n_num;
        r_dv_rem[0]  <= '0;
        r_dv_q[0]    <= '0;
    end

    for (genvar i = 0; i < DIV_W; i++) begin : g_dv
        logic [DV_REM_W:0] rem_sh;
        logic              ge;
        logic [DV_REM_W:0] diff;

        always_comb begin
            rem_sh = {r_dv_rem[i], r_dv_num[i][DIV_W-1]};
            ge     = rem_sh >= {1'b0, r_dv_den[i]};
            diff   = rem_sh - {1'b0, r_dv_den[i]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_item[i+1] <= '0;
            end else begin
                r_dv_item[i+1] <= r_dv_item[i];
            end
            r_dv_den[i+1]  <= r_dv_den[i];
            r_dv_num[i+1]  <= {r_dv_num[i][DIV_W-2:0], 1'b0};
            r_dv_rem[i+1]  <= ge ? diff[DV_REM_W-1:0] : rem_sh[DV_REM_W-1:0];
            r_dv_q[i+1]    <= {r_dv_q[i][DIV_W-2:0], ge};
        end
    end

    // Final stage: apply the step and saturate the weight.
    rwu_pkg::t_item    n_last;
    logic [49:0]       n_w_ext;
    logic [49:0]       n_step_ext;
    logic [49:0]       n_res;
    logic              n_wclip;
    logic [DATA_W-1:0] n_wout;
    logic              r_fin_valid;
    logic [DATA_W-1:0] r_fin_weight;
    logic              r_fin_sat;

    always_comb begin
        n_last     = r_dv_item[DIV_W];
        n_w_ext    = {{18{n_last.weight[31]}}, n_last.weight};
        n_step_ext = {2'b00, r_dv_q[DIV_W]};
        n_res      = n_last.neg ? (n_w_ext + n_step_ext) : (n_w_ext - n_step_ext);
        n_wclip    = !((&n_res[49:31]) || !(|n_res[49:31]));
        if (n_wclip) begin
            n_wout = n_res[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_wout = n_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_weight <= n_wout;
        r_fin_sat    <= n_last.sat | n_wclip;
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_last.valid;
        end
    end

    // Output queue with the output register as its read data register.
    logic [DATA_W:0]   r_ofifo [FIFO_DEPTH];
    logic [FW-1:0]     r_wr_ptr;
    logic [FW-1:0]     r_rd_ptr;
    logic [FW:0]       r_fcount;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_weight;
    logic              r_out_sat;
    logic              n_load;

    assign n_load = (r_fcount != '0) && (!r_out_valid || n_take);

    always_ff @(posedge i_clk) begin
        if (r_fin_valid) begin
            r_ofifo[r_wr_ptr] <= {r_fin_sat, r_fin_weight};
        end
        if (n_load) begin
            {r_out_sat, r_out_weight} <= r_ofifo[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_fin_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (n_load) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fcount <= r_fcount + (FW+1)'(r_fin_valid) - (FW+1)'(n_load);
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (n_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_weight_out = r_out_weight;
    assign o_saturated  = r_out_sat;

    `RWU_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1, r_used <= FIFO_FULL)
    `RWU_ASSERT_IMPL(a_queue_room, i_clk, i_rst_n, r_fin_valid, r_fcount < FIFO_FULL)
    `RWU_ASSERT_IMPL(a_no_update_in_clear, i_clk, i_rst_n, r_clr_busy, !n_upd_we)
    `RWU_ASSERT_IMPL(a_out_has_credit, i_clk, i_rst_n, o_valid, r_used != '0)
    `RWU_ASSERT_NEXT(a_credit_return, i_clk, i_rst_n, n_take && !n_acc, r_used == $past(r_used) - 1'b1)

endmodule

// ===== verif/rmsprop_weight_update_tb.sv =====
// Self-checking testbench for the RMSprop weight update block with a fixed-point predictor.
`timescale 1ns / 1ps

module rmsprop_weight_update_tb;

    localparam int LAYERS   = 8;
    localparam int ELEMS    = 1024;
    localparam int DEPTH    = LAYERS * ELEMS;
    localparam int LATENCY  = 200;
    localparam int IDLE_LIMIT = DEPTH + 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [31:0] weight;
        logic               sat;
    } t_update;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_layer_index = '0;
    logic [9:0]         i_element_index = '0;
    logic signed [31:0] i_gradient = '0;
    logic signed [31:0] i_weight_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_weight_out;
    logic               o_saturated;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    rmsprop_weight_update i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [31:0]    cache_model [DEPTH];
    logic [15:0]    alpha;
    logic [15:0]    rho;
    t_update        pending_updates [$];
    int             errors = 0;
    int             idle_cycles = 0;
    bit             sender_idles = 1'b1;
    bit             receiver_idles = 1'b1;
    bit             hold_receiver = 1'b0;
    int             hold_count = 0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_update predict_update(logic [2:0] layer, logic [9:0] elem,
                                               logic [31:0] grad, logic [31:0] w);
        t_update u;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] c;
        logic [63:0] den;
        logic [63:0] stp;
        logic signed [65:0] res;
        int addr;
        u.sat = 1'b0;
        mag = grad[31] ? {32'd0, -grad} : {32'd0, grad};
        if (grad == 32'h8000_0000) mag = 64'h8000_0000;
        addr = layer * ELEMS + elem;
        sq = (mag * mag) >> 16;
        c = ((64'(cache_model[addr]) * rho) >> 16) + ((sq * (64'd65536 - rho)) >> 16);
        if (c > 64'hFFFF_FFFF) begin
            c = 64'hFFFF_FFFF;
            u.sat = 1'b1;
        end
        cache_model[addr] = c[31:0];
        den = isqrt(c << 16) + 1;
        stp = (64'(alpha) * mag) / den;
        res = grad[31] ? 66'($signed(w)) + 66'(stp) : 66'($signed(w)) - 66'(stp);
        if (res > 66'sd2147483647) begin
            res = 66'sd2147483647;
            u.sat = 1'b1;
        end else if (res < -66'sd2147483648) begin
            res = -66'sd2147483648;
            u.sat = 1'b1;
        end
        u.weight = res[31:0];
        return u;
    endfunction

    task automatic write_reg(rwu_pkg::t_reg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= {16'hA5A5, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == rwu_pkg::REG_LEARNING_RATE) alpha = value;
        else rho = value;
    endtask

    task automatic send_item(logic [2:0] layer, logic [9:0] elem,
                             logic [31:0] grad, logic [31:0] w);
        while (sender_idles && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_layer_index <= layer;
        i_element_index <= elem;
        i_gradient <= grad;
        i_weight_in <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_updates.push_back(predict_update(layer, elem, grad, w));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(255) - 128;
            1: return $urandom_range(32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(0, 0, 32'h0001_0000, 32'h0002_0000);
        send_item(0, 0, 32'h0001_0000, 32'h0002_0000);
        send_item(7, 1023, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(7, 1023, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(3, 5, 32'h0, 32'hFFFF_FFFF);
        send_item(3, 6, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(3, 7, 32'h0000_0001, 32'h8000_0000);
        send_item(5, 512, 32'h7FFF_FFFF, 32'h0);
        send_item(5, 512, 32'h7FFF_FFFF, 32'h0);
        drain();
    endtask

    task automatic test_rate_extremes();
        write_reg(rwu_pkg::REG_LEARNING_RATE, 16'hFFFF);
        write_reg(rwu_pkg::REG_DECAY_RATE, 16'h0000);
        send_item(1, 1, 32'h0000_0010, 32'h7FFF_FF00);
        send_item(1, 2, 32'hFFFF_FFF0, 32'h8000_0100);
        send_item(1, 3, 32'h7FFF_FFFF, 32'h1234_5678);
        drain();
        write_reg(rwu_pkg::REG_LEARNING_RATE, 16'h0000);
        write_reg(rwu_pkg::REG_DECAY_RATE, 16'hFFFF);
        send_item(1, 3, 32'h8000_0000, 32'h5555_AAAA);
        send_item(2, 9, 32'h0003_0000, 32'hAAAA_5555);
        drain();
    endtask

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
            send_item(3'($urandom_range(7)),
                      10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15)),
                      rand_word(), rand_word());
    endtask

    task automatic test_random();
        logic [15:0] rates [4] = '{16'd66, 16'd58982, 16'd1, 16'd40000};
        for (int p = 0; p < 4; p++) begin
            write_reg(rwu_pkg::REG_LEARNING_RATE, (p == 3) ? 16'($urandom) : rates[p]);
            write_reg(rwu_pkg::REG_DECAY_RATE, (p == 3) ? 16'($urandom) : rates[3 - p]);
            sender_idles = (p != 1);
            receiver_idles = (p != 1);
            random_burst(200);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_receiver = 1'b1;
        sender_idles = 1'b0;
        random_burst(150);
        hold_receiver = 1'b0;
        sender_idles = 1'b1;
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_receiver && hold_count < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= receiver_idles && ($urandom_range(99) < 36);
        end
    end

    always @(posedge i_clk) begin
        t_update exp_u;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected result weight_out=%h", o_weight_out);
                errors++;
            end else begin
                exp_u = pending_updates.pop_front();
                if (o_weight_out !== exp_u.weight) begin
                    $error("weight_out expected %h actual %h", exp_u.weight, o_weight_out);
                    errors++;
                end
                if (o_saturated !== exp_u.sat) begin
                    $error("saturated expected %b actual %b", exp_u.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < DEPTH; a++) cache_model[a] = '0;
        alpha = rwu_pkg::LR_RESET;
        rho = rwu_pkg::DR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_rate_extremes();
        test_random();
        test_backpressure();
        if (errors == 0 && pending_updates.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ===== rmsprop_weight_update.f =====
+incdir+rtl
rtl/rwu_pkg.sv
rtl/rmsprop_weight_update.sv
verif/rmsprop_weight_update_tb.sv
